[hdl/rub_pkg.sv]
// ----------------------------------------------------------------------------
// rub_pkg
// Shared widths, register codes and pipeline types for the radial
// undistortion block.
// ----------------------------------------------------------------------------
package rub_pkg;

  localparam int unsigned DIM_W     = 11;  // frame size and pixel index
  localparam int unsigned CRD_W     = 10;  // request coordinates
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COEF_W    = 20;  // signed Q4.16
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

  // radius term divider: (d^2 << 15) / c^2, at most 2^15 for in-frame computes
  localparam int unsigned QB     = 16;
  localparam int unsigned SQ_W   = 2 * CRD_W;
  localparam int unsigned NUM_SH = 15;
  localparam int unsigned REM_W  = SQ_W + NUM_SH;

  localparam int unsigned R2_W   = 17;               // Q1.16, up to 1.0
  localparam int unsigned T_W    = COEF_W + R2_W + 1; // k * r2 product
  localparam int unsigned FAC_W  = 40;               // Q.32 radial factor
  localparam int unsigned V_W    = FAC_W + DIM_W + 1; // d * factor
  localparam int unsigned MAP_SH = 24;
  localparam int unsigned SX_W   = 29;               // Q.8 source coordinate
  localparam int unsigned WGT_W  = 17;
  localparam int unsigned ACC_W  = 25;

  localparam logic signed [FAC_W-1:0] FAC_ONE = 40'sh01_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1     = 3'd0,
    REG_K2     = 3'd1,
    REG_K3     = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_e;

  // loads carry their raw coordinates in dx/dy, bad marks an ignored load or an out-of-frame compute
  typedef struct packed {
    logic                    ld;
    logic                    bad;
    logic signed [DIM_W:0]   dx;
    logic signed [DIM_W:0]   dy;
    logic [PIX_W-1:0]        pix;
  } tag_t;

endpackage

[hdl/radial_undistort_bilinear.sv]
// ----------------------------------------------------------------------------
// radial_undistort_bilinear
// Radial lens distortion correction with bilinear resampling of a stored
// 8-bit frame, fully pipelined.
// ----------------------------------------------------------------------------
// output: each compute request gives one done_o word; load requests give
//   no word
// throughput: one request per clock, busy_o is never high; the 16-stage
//   radius divider and four frame banks (split by row and column parity) set
//   the depth, loads write at the same stage where computes read
// reset: clears coefficients, sets the frame size to 640 x 480 and clears
//   pipeline valids; frame contents are undefined until loaded
module radial_undistort_bilinear #(
  parameter int unsigned MAX_WIDTH  = rub_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rub_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [rub_pkg::CRD_W-1:0]       coord_x_i,
  input  logic [rub_pkg::CRD_W-1:0]       coord_y_i,
  input  logic [rub_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                            done_o,
  output logic [rub_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                            outside_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rub_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rub_pkg::COEF_W-1:0]      cfg_data_i
);

  localparam int unsigned HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned XB         = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int unsigned YB         = (HALF_H > 1) ? $clog2(HALF_H) : 1;
  localparam int unsigned AW         = XB + YB;
  localparam int unsigned BANK_DEPTH = 1 << AW;

  localparam int unsigned DIM_W  = rub_pkg::DIM_W;
  localparam int unsigned CRD_W  = rub_pkg::CRD_W;
  localparam int unsigned PIX_W  = rub_pkg::PIX_W;
  localparam int unsigned COEF_W = rub_pkg::COEF_W;
  localparam int unsigned QB     = rub_pkg::QB;
  localparam int unsigned SQ_W   = rub_pkg::SQ_W;
  localparam int unsigned REM_W  = rub_pkg::REM_W;
  localparam int unsigned R2_W   = rub_pkg::R2_W;
  localparam int unsigned T_W    = rub_pkg::T_W;
  localparam int unsigned FAC_W  = rub_pkg::FAC_W;
  localparam int unsigned V_W    = rub_pkg::V_W;
  localparam int unsigned SX_W   = rub_pkg::SX_W;
  localparam int unsigned WGT_W  = rub_pkg::WGT_W;
  localparam int unsigned ACC_W  = rub_pkg::ACC_W;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] k1_q, k2_q, k3_q;
  logic [DIM_W-1:0]         fw_q, fh_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      fw_q <= rub_pkg::RST_WIDTH;
      fh_q <= rub_pkg::RST_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (rub_pkg::cfg_reg_e'(cfg_index_i))
        rub_pkg::REG_K1:     k1_q <= cfg_data_i;
        rub_pkg::REG_K2:     k2_q <= cfg_data_i;
        rub_pkg::REG_K3:     k3_q <= cfg_data_i;
        rub_pkg::REG_WIDTH:  fw_q <= cfg_data_i[DIM_W-1:0];
        rub_pkg::REG_HEIGHT: fh_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_s, h_s;
  logic [CRD_W-1:0] xc, yc;
  logic [SQ_W-1:0]  cxx_q, cyy_q;

  always_comb begin
    if (fw_q < DIM_W'(2)) begin
      w_s = DIM_W'(2);
    end else if (fw_q > MAX_WIDTH) begin
      w_s = DIM_W'(MAX_WIDTH);
    end else begin
      w_s = fw_q;
    end
    if (fh_q < DIM_W'(2)) begin
      h_s = DIM_W'(2);
    end else if (fh_q > MAX_HEIGHT) begin
      h_s = DIM_W'(MAX_HEIGHT);
    end else begin
      h_s = fh_q;
    end
  end

  assign xc = w_s[DIM_W-1:1];
  assign yc = h_s[DIM_W-1:1];

  // divisors are registered from the settled configuration and read by every divider stage
  always_ff @(posedge clk_i) begin
    cxx_q <= SQ_W'(xc) * SQ_W'(xc);
    cyy_q <= SQ_W'(yc) * SQ_W'(yc);
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic             s0_v_q, s0_ld_q;
  logic [CRD_W-1:0] s0_x_q, s0_y_q;
  logic [PIX_W-1:0] s0_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s0_ld_q  <= ~req_type_i;
      s0_x_q   <= coord_x_i;
      s0_y_q   <= coord_y_i;
      s0_pix_q <= pixel_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // offsets from center and squared distances
  // --------------------------------------------------------------------------
  logic signed [DIM_W:0] dx0, dy0;
  logic [CRD_W-1:0]      ax0, ay0;
  logic [SQ_W-1:0]       sqx0, sqy0;
  logic                  bad0;

  always_comb begin
    if (s0_ld_q) begin
      dx0  = $signed({2'b00, s0_x_q});
      dy0  = $signed({2'b00, s0_y_q});
      bad0 = (s0_x_q >= MAX_WIDTH) || (s0_y_q >= MAX_HEIGHT);
    end else begin
      dx0  = $signed({2'b00, s0_x_q}) - $signed({2'b00, xc});
      dy0  = $signed({2'b00, s0_y_q}) - $signed({2'b00, yc});
      bad0 = ({1'b0, s0_x_q} >= w_s) || ({1'b0, s0_y_q} >= h_s);
    end
    ax0  = dx0[DIM_W] ? CRD_W'(-dx0) : CRD_W'(dx0);
    ay0  = dy0[DIM_W] ? CRD_W'(-dy0) : CRD_W'(dy0);
    sqx0 = SQ_W'(ax0) * SQ_W'(ax0);
    sqy0 = SQ_W'(ay0) * SQ_W'(ay0);
  end

  // --------------------------------------------------------------------------
  // radius divider, one quotient bit per stage; entry 0 holds the dividends
  // --------------------------------------------------------------------------
  logic                 dv_v_q  [QB+1];
  rub_pkg::tag_t        dv_tag_q[QB+1];
  logic [REM_W-1:0]     dv_rx_q [QB+1];
  logic [REM_W-1:0]     dv_ry_q [QB+1];
  logic [QB-1:0]        dv_qx_q [QB+1];
  logic [QB-1:0]        dv_qy_q [QB+1];

  logic [REM_W:0]       dsx [1:QB];
  logic [REM_W:0]       dsy [1:QB];
  logic [REM_W-1:0]     nrx [1:QB];
  logic [REM_W-1:0]     nry [1:QB];
  logic [QB-1:0]        nqx [1:QB];
  logic [QB-1:0]        nqy [1:QB];

  always_comb begin
    for (int i = 1; i <= QB; i++) begin
      dsx[i] = (REM_W+1)'(cxx_q) << (QB - i);
      dsy[i] = (REM_W+1)'(cyy_q) << (QB - i);
      if ({1'b0, dv_rx_q[i-1]} >= dsx[i]) begin
        nrx[i] = REM_W'({1'b0, dv_rx_q[i-1]} - dsx[i]);
        nqx[i] = dv_qx_q[i-1] | (QB'(1) << (QB - i));
      end else begin
        nrx[i] = dv_rx_q[i-1];
        nqx[i] = dv_qx_q[i-1];
      end
      if ({1'b0, dv_ry_q[i-1]} >= dsy[i]) begin
        nry[i] = REM_W'({1'b0, dv_ry_q[i-1]} - dsy[i]);
        nqy[i] = dv_qy_q[i-1] | (QB'(1) << (QB - i));
      end else begin
        nry[i] = dv_ry_q[i-1];
        nqy[i] = dv_qy_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QB; i++) begin
        dv_v_q[i] <= 1'b0;
      end
    end else begin
      dv_v_q[0] <= s0_v_q;
      for (int i = 1; i <= QB; i++) begin
        dv_v_q[i] <= dv_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_tag_q[0] <= '{ld: s0_ld_q, bad: bad0, dx: dx0, dy: dy0, pix: s0_pix_q};
    dv_rx_q[0]  <= {sqx0, rub_pkg::NUM_SH'(0)};
    dv_ry_q[0]  <= {sqy0, rub_pkg::NUM_SH'(0)};
    dv_qx_q[0]  <= '0;
    dv_qy_q[0]  <= '0;
    for (int i = 1; i <= QB; i++) begin
      dv_tag_q[i] <= dv_tag_q[i-1];
      dv_rx_q[i]  <= nrx[i];
      dv_ry_q[i]  <= nry[i];
      dv_qx_q[i]  <= nqx[i];
      dv_qy_q[i]  <= nqy[i];
    end
  end

  // --------------------------------------------------------------------------
  // radial factor
  // --------------------------------------------------------------------------
  logic                     p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q;
  rub_pkg::tag_t            p1_tag_q, p2_tag_q, p3_tag_q, p4_tag_q, p5_tag_q;
  rub_pkg::tag_t            p6_tag_q;
  logic [R2_W-1:0]          p1_r2_q, p2_r2_q, p2_r2b_q, p3_r2c_q;
  logic signed [T_W-1:0]    p2_t1_q, p3_t1_q, p3_t2_q, p4_t3_q;
  logic signed [FAC_W-1:0]  p4_s12_q, p5_fac_q;
  logic signed [V_W-1:0]    p6_vx_q, p6_vy_q;

  logic [2*R2_W-1:0]        sq_r2, sq_r2c;
  logic signed [T_W-1:0]    t1_c, t2_c, t3_c;

  assign sq_r2  = (2*R2_W)'(p1_r2_q) * (2*R2_W)'(p1_r2_q);
  assign sq_r2c = (2*R2_W)'(p2_r2b_q) * (2*R2_W)'(p2_r2_q);
  assign t1_c   = T_W'(k1_q) * T_W'($signed({1'b0, p1_r2_q}));
  assign t2_c   = T_W'(k2_q) * T_W'($signed({1'b0, p2_r2b_q}));
  assign t3_c   = T_W'(k3_q) * T_W'($signed({1'b0, p3_r2c_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
    end else begin
      p1_v_q <= dv_v_q[QB];
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_tag_q <= dv_tag_q[QB];
    p1_r2_q  <= R2_W'(dv_qx_q[QB]) + R2_W'(dv_qy_q[QB]);

    p2_tag_q <= p1_tag_q;
    p2_r2_q  <= p1_r2_q;
    p2_r2b_q <= sq_r2[R2_W+15:16];
    p2_t1_q  <= t1_c;

    p3_tag_q <= p2_tag_q;
    p3_r2c_q <= sq_r2c[R2_W+15:16];
    p3_t1_q  <= p2_t1_q;
    p3_t2_q  <= t2_c;

    p4_tag_q <= p3_tag_q;
    p4_s12_q <= FAC_W'(p3_t1_q) + FAC_W'(p3_t2_q);
    p4_t3_q  <= t3_c;

    p5_tag_q <= p4_tag_q;
    p5_fac_q <= rub_pkg::FAC_ONE + p4_s12_q + FAC_W'(p4_t3_q);

    p6_tag_q <= p5_tag_q;
    p6_vx_q  <= V_W'(p5_tag_q.dx) * V_W'(p5_fac_q);
    p6_vy_q  <= V_W'(p5_tag_q.dy) * V_W'(p5_fac_q);
  end

  // --------------------------------------------------------------------------
  // source point, floor and fraction
  // --------------------------------------------------------------------------
  logic signed [SX_W-1:0] sx, sy;
  logic                   out_map;

  assign sx = SX_W'(p6_vx_q >>> rub_pkg::MAP_SH) + SX_W'({xc, 8'd0});
  assign sy = SX_W'(p6_vy_q >>> rub_pkg::MAP_SH) + SX_W'({yc, 8'd0});
  assign out_map = sx[SX_W-1] || sy[SX_W-1]
                || (sx[SX_W-2:0] >= (SX_W-1)'({w_s, 8'd0}))
                || (sy[SX_W-2:0] >= (SX_W-1)'({h_s, 8'd0}));

  logic             p7_v_q, p7_ld_q, p7_bad_q;
  logic [PIX_W-1:0] p7_pix_q;
  logic [DIM_W-1:0] p7_ix_q, p7_iy_q;
  logic [7:0]       p7_fx_q, p7_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p7_v_q <= 1'b0;
    end else begin
      p7_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p7_ld_q  <= p6_tag_q.ld;
    p7_pix_q <= p6_tag_q.pix;
    if (p6_tag_q.ld) begin
      p7_bad_q <= p6_tag_q.bad;
      p7_ix_q  <= p6_tag_q.dx[DIM_W-1:0];
      p7_iy_q  <= p6_tag_q.dy[DIM_W-1:0];
      p7_fx_q  <= '0;
      p7_fy_q  <= '0;
    end else begin
      p7_bad_q <= p6_tag_q.bad || out_map;
      p7_ix_q  <= sx[DIM_W+7:8];
      p7_iy_q  <= sy[DIM_W+7:8];
      p7_fx_q  <= sx[7:0];
      p7_fy_q  <= sy[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // frame banks: bank index is {row parity, column parity}
  // --------------------------------------------------------------------------
  logic [DIM_W:0]   ixp, iyp;
  logic [DIM_W-1:0] ix1, iy1;
  logic [DIM_W-1:0] bcol [4];
  logic [DIM_W-1:0] brow [4];
  logic [AW-1:0]    bank_addr [4];
  logic             bank_we [4];
  logic [PIX_W-1:0] bank_rd [4];

  always_comb begin
    ixp = {1'b0, p7_ix_q} + (DIM_W+1)'(1);
    iyp = {1'b0, p7_iy_q} + (DIM_W+1)'(1);
    // neighbours past the last column or row fall back to the edge
    ix1 = (ixp < {1'b0, w_s}) ? ixp[DIM_W-1:0] : w_s - DIM_W'(1);
    iy1 = (iyp < {1'b0, h_s}) ? iyp[DIM_W-1:0] : h_s - DIM_W'(1);
    for (int b = 0; b < 4; b++) begin
      bcol[b]      = (p7_ix_q[0] == b[0]) ? p7_ix_q : ix1;
      brow[b]      = (p7_iy_q[0] == b[1]) ? p7_iy_q : iy1;
      bank_addr[b] = {YB'(brow[b] >> 1), XB'(bcol[b] >> 1)};
      bank_we[b]   = p7_v_q && p7_ld_q && !p7_bad_q
                  && (p7_ix_q[0] == b[0]) && (p7_iy_q[0] == b[1]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rub_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .addr_i (bank_addr[g]),
      .wdata_i(p7_pix_q),
      .rdata_o(bank_rd[g])
    );
  end

  // --------------------------------------------------------------------------
  // blend weights alongside the bank read
  // --------------------------------------------------------------------------
  logic [8:0]       wx0, wy0;
  logic             p8_emit_q, p8_bad_q;
  logic             p8_x0_q, p8_x1_q, p8_y0_q, p8_y1_q;
  logic [WGT_W-1:0] p8_w00_q, p8_w01_q, p8_w10_q, p8_w11_q;

  assign wx0 = 9'd256 - {1'b0, p7_fx_q};
  assign wy0 = 9'd256 - {1'b0, p7_fy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p8_emit_q <= 1'b0;
    end else begin
      p8_emit_q <= p7_v_q && !p7_ld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p8_bad_q <= p7_bad_q;
    p8_x0_q  <= p7_ix_q[0];
    p8_x1_q  <= ix1[0];
    p8_y0_q  <= p7_iy_q[0];
    p8_y1_q  <= iy1[0];
    p8_w00_q <= WGT_W'(wx0) * WGT_W'(wy0);
    p8_w01_q <= WGT_W'(p7_fx_q) * WGT_W'(wy0);
    p8_w10_q <= WGT_W'(wx0) * WGT_W'(p7_fy_q);
    p8_w11_q <= WGT_W'(p7_fx_q) * WGT_W'(p7_fy_q);
  end

  // --------------------------------------------------------------------------
  // blend and output word
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] acc;
  logic             done_q, outside_q;
  logic [PIX_W-1:0] pix_q;

  assign acc = ACC_W'(bank_rd[{p8_y0_q, p8_x0_q}]) * ACC_W'(p8_w00_q)
             + ACC_W'(bank_rd[{p8_y0_q, p8_x1_q}]) * ACC_W'(p8_w01_q)
             + ACC_W'(bank_rd[{p8_y1_q, p8_x0_q}]) * ACC_W'(p8_w10_q)
             + ACC_W'(bank_rd[{p8_y1_q, p8_x1_q}]) * ACC_W'(p8_w11_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p8_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    outside_q <= p8_bad_q;
    pix_q     <= p8_bad_q ? '0 : acc[23:16];
  end

  assign done_o      = done_q;
  assign outside_o   = outside_q;
  assign pixel_out_o = pix_q;

endmodule

[hdl/rub_ram.sv]
// ----------------------------------------------------------------------------
// rub_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rub_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[test/radial_undistort_bilinear_tb.sv]
// ----------------------------------------------------------------------------
// radial_undistort_bilinear_tb
// Loads source pixels and requests corrected pixels under a series of lens
// coefficient and frame size settings, and checks every returned word
// against directed values or a fixed-point predictor of the radial mapping and bilinear blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_undistort_bilinear_tb;

  localparam int unsigned STORE_W  = 1024;
  localparam int unsigned STORE_H  = 1024;
  localparam int unsigned LATENCY  = 30;
  localparam int unsigned N_PHASES = 10;
  localparam int unsigned PHASE_N  = 30;
  localparam logic [rub_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef enum bit {REQ_LOAD = 1'b0, REQ_COMPUTE = 1'b1} req_e;

  typedef struct {
    logic [rub_pkg::PIX_W-1:0] pix;
    logic                      outside;
  } pix_word_t;

  typedef struct {
    req_e kind;
    int   x;
    int   y;
    int   pix;
    bit   typed;
    int   exp_pix;
    bit   exp_out;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic                          req_type_i;
  logic [rub_pkg::CRD_W-1:0]     coord_x_i;
  logic [rub_pkg::CRD_W-1:0]     coord_y_i;
  logic [rub_pkg::PIX_W-1:0]     pixel_in_i;
  logic                          done_o;
  logic [rub_pkg::PIX_W-1:0]     pixel_out_o;
  logic                          outside_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rub_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rub_pkg::COEF_W-1:0]    cfg_data_i;

  radial_undistort_bilinear u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .pixel_in_i  (pixel_in_i),
    .done_o      (done_o),
    .pixel_out_o (pixel_out_o),
    .outside_o   (outside_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [rub_pkg::PIX_W-1:0] frame_mem [STORE_W*STORE_H];
  bit                        loaded    [STORE_W*STORE_H];
  longint                    k1_q, k2_q, k3_q;
  int unsigned               width_q, height_q;

  pix_word_t pending_q[$];
  int        errors = 0;
  int        burst_left = 0;

  function automatic longint radius_term(longint d, longint c);
    longint a;
    a = (d < 0) ? -d : d;
    return ((a * a) << 15) / (c * c);
  endfunction

  function automatic int unsigned sat_dim(int unsigned v);
    if (v < 2) return 2;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // corrected pixel and the four store addresses it blends
  function automatic void undistort(input int x, input int y, output pix_word_t res,
                                    output int nb[4]);
    int unsigned w, h, ix, iy, ix1, iy1, fx, fy, acc;
    longint xc, yc, dx, dy, r2, r2b, r2c, fac, sx, sy;
    res.pix = '0;
    res.outside = 1'b1;
    for (int i = 0; i < 4; i++) nb[i] = -1;
    w = sat_dim(width_q);
    h = sat_dim(height_q);
    if (x >= w || y >= h) return;
    xc = w / 2;
    yc = h / 2;
    dx = x - xc;
    dy = y - yc;
    r2  = radius_term(dy, yc) + radius_term(dx, xc);
    r2b = (r2 * r2) >> 16;
    r2c = (r2b * r2) >> 16;
    fac = (64'sd1 <<< 32) + k1_q * r2 + k2_q * r2b + k3_q * r2c;
    sx = ((dx * fac) >>> 24) + xc * 256;
    sy = ((dy * fac) >>> 24) + yc * 256;
    if (sx < 0 || sy < 0 || sx >= longint'(w) * 256 || sy >= longint'(h) * 256) return;
    ix = sx >> 8;
    iy = sy >> 8;
    fx = sx & 255;
    fy = sy & 255;
    ix1 = (ix + 1 < w) ? ix + 1 : w - 1;
    iy1 = (iy + 1 < h) ? iy + 1 : h - 1;
    nb[0] = iy * STORE_W + ix;
    nb[1] = iy * STORE_W + ix1;
    nb[2] = iy1 * STORE_W + ix;
    nb[3] = iy1 * STORE_W + ix1;
    acc = frame_mem[nb[0]] * (256 - fx) * (256 - fy) + frame_mem[nb[1]] * fx * (256 - fy)
        + frame_mem[nb[2]] * (256 - fx) * fy + frame_mem[nb[3]] * fx * fy;
    res.pix = acc[23:16];
    res.outside = 1'b0;
  endfunction

  // drive one request word from a falling edge, keep start high inside a burst
  task automatic send_req(req_e kind, int x, int y, int pix, bit typed = 0,
                          int exp_pix = 0, bit exp_out = 0);
    pix_word_t res;
    int        nb[4];
    start_i    <= 1'b1;
    req_type_i <= kind;
    coord_x_i  <= x[rub_pkg::CRD_W-1:0];
    coord_y_i  <= y[rub_pkg::CRD_W-1:0];
    pixel_in_i <= pix[rub_pkg::PIX_W-1:0];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (kind == REQ_LOAD) begin
      frame_mem[y * STORE_W + x] = pix[rub_pkg::PIX_W-1:0];
      loaded[y * STORE_W + x] = 1'b1;
    end else begin
      undistort(x, y, res, nb);
      if (typed) begin
        res.pix = exp_pix[rub_pkg::PIX_W-1:0];
        res.outside = exp_out;
      end
      pending_q.push_back(res);
    end
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // fill any never-loaded neighbour first so no read hits an unwritten entry
  task automatic send_compute(int x, int y, bit typed = 0, int exp_pix = 0,
                              bit exp_out = 0);
    pix_word_t res;
    int        nb[4];
    undistort(x, y, res, nb);
    if (!res.outside) begin
      for (int i = 0; i < 4; i++) begin
        if (!loaded[nb[i]])
          send_req(REQ_LOAD, nb[i] % STORE_W, nb[i] / STORE_W, $urandom_range(0, 255));
      end
    end
    send_req(REQ_COMPUTE, x, y, $urandom_range(0, 255), typed, exp_pix, exp_out);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(logic [rub_pkg::CFG_IDX_W-1:0] idx,
                           logic [rub_pkg::COEF_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      rub_pkg::REG_K1:     k1_q = longint'($signed(data));
      rub_pkg::REG_K2:     k2_q = longint'($signed(data));
      rub_pkg::REG_K3:     k3_q = longint'($signed(data));
      rub_pkg::REG_WIDTH:  width_q = data[rub_pkg::DIM_W-1:0];
      rub_pkg::REG_HEIGHT: height_q = data[rub_pkg::DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [rub_pkg::COEF_W-1:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return rub_pkg::COEF_W'($urandom_range(0, 20'hFFFFF));
    return rub_pkg::COEF_W'($urandom_range(0, 40000) - 20000);
  endfunction

  function automatic logic [rub_pkg::COEF_W-1:0] rand_dim();
    logic [rub_pkg::COEF_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = rub_pkg::COEF_W'($urandom_range(2, 1024));
      1:       v = rub_pkg::COEF_W'(1024);
      default: v = rub_pkg::COEF_W'($urandom_range(2, 48));
    endcase
    // upper data bits are not part of the size register
    v[rub_pkg::COEF_W-1:rub_pkg::DIM_W] =
        (rub_pkg::COEF_W - rub_pkg::DIM_W)'($urandom_range(0, 511));
    return v;
  endfunction

  // directed words right after reset: 640 x 480, all coefficients zero
  stim_row_t directed[] = '{
    '{REQ_COMPUTE, 640, 0, 0, 1, 0, 1},
    '{REQ_COMPUTE, 0, 480, 0, 1, 0, 1},
    '{REQ_COMPUTE, 1023, 1023, 0, 1, 0, 1},
    '{REQ_LOAD, 320, 240, 8'hA5, 0, 0, 0},
    '{REQ_COMPUTE, 320, 240, 0, 1, 8'hA5, 0},
    '{REQ_LOAD, 0, 0, 8'hFF, 0, 0, 0},
    '{REQ_COMPUTE, 0, 0, 0, 1, 8'hFF, 0},
    '{REQ_LOAD, 639, 479, 8'h00, 0, 0, 0},
    '{REQ_COMPUTE, 639, 479, 0, 1, 8'h00, 0},
    '{REQ_LOAD, 1023, 1023, 8'h5A, 0, 0, 0},
    '{REQ_LOAD, 1023, 0, 8'h80, 0, 0, 0},
    '{REQ_LOAD, 0, 1023, 8'h01, 0, 0, 0},
    '{REQ_LOAD, 512, 341, 8'h7F, 0, 0, 0},
    '{REQ_COMPUTE, 639, 0, 0, 0, 0, 0},
    '{REQ_COMPUTE, 0, 479, 0, 0, 0, 0},
    '{REQ_COMPUTE, 319, 239, 0, 0, 0, 0},
    '{REQ_COMPUTE, 100, 50, 0, 0, 0, 0},
    '{REQ_COMPUTE, 639, 480, 0, 1, 0, 1}
  };

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word pixel_out=%0d outside=%0b", $time,
                 pixel_out_o, outside_o);
        errors++;
      end else begin
        pix_word_t want;
        want = pending_q.pop_front();
        if (pixel_out_o !== want.pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pix, pixel_out_o);
          errors++;
        end
        if (outside_o !== want.outside) begin
          $display("%0t: outside expected %0b actual %0b", $time, want.outside, outside_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int x, y, w, h;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_type_i = 1'b0;
    coord_x_i = '0;
    coord_y_i = '0;
    pixel_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rub_pkg::REG_K1;
    cfg_data_i = '0;
    k1_q = 0;
    k2_q = 0;
    k3_q = 0;
    width_q = rub_pkg::RST_WIDTH;
    height_q = rub_pkg::RST_HEIGHT;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == REQ_LOAD)
        send_req(REQ_LOAD, directed[i].x, directed[i].y, directed[i].pix);
      else
        send_compute(directed[i].x, directed[i].y, directed[i].typed,
                     directed[i].exp_pix, directed[i].exp_out);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(rub_pkg::REG_K1, 20'h7FFFF);
          write_reg(rub_pkg::REG_K2, 20'h80000);
          write_reg(rub_pkg::REG_K3, 20'h00000);
          write_reg(rub_pkg::REG_WIDTH, 20'd1024);
          write_reg(rub_pkg::REG_HEIGHT, 20'd1024);
        end
        1: begin
          write_reg(rub_pkg::REG_K1, 20'h80000);
          write_reg(rub_pkg::REG_K2, 20'h7FFFF);
          write_reg(rub_pkg::REG_K3, 20'h80000);
          write_reg(rub_pkg::REG_WIDTH, 20'd2);
          write_reg(rub_pkg::REG_HEIGHT, 20'd2);
        end
        2: begin
          write_reg(rub_pkg::REG_K1, rand_coef());
          write_reg(rub_pkg::REG_K3, 20'h7FFFF);
          write_reg(rub_pkg::REG_WIDTH, 20'd0);
          write_reg(rub_pkg::REG_HEIGHT, 20'd2047);
          write_reg(REG_UNUSED, 20'hFFFFF);
        end
        3: begin
          write_reg(rub_pkg::REG_K2, rand_coef());
          write_reg(rub_pkg::REG_WIDTH, 20'hFF801);
          write_reg(rub_pkg::REG_HEIGHT, 20'd1);
        end
        default: begin
          write_reg(rub_pkg::REG_K1, rand_coef());
          write_reg(rub_pkg::REG_K2, rand_coef());
          write_reg(rub_pkg::REG_K3, rand_coef());
          write_reg(rub_pkg::REG_WIDTH, rand_dim());
          write_reg(rub_pkg::REG_HEIGHT, rand_dim());
          if ($urandom_range(0, 2) == 0)
            write_reg(rub_pkg::CFG_IDX_W'($urandom_range(5, 7)),
                      rub_pkg::COEF_W'($urandom));
        end
      endcase
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);
      w = sat_dim(width_q);
      h = sat_dim(height_q);
      for (int n = 0; n < PHASE_N; n++) begin
        if (p == 1 && n == PHASE_N / 2) drain();
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
          0, 1:    send_req(REQ_LOAD, x, y, $urandom_range(0, 255));
          2:       send_compute(x, y);
          default: send_compute($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        endcase
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rub_pkg.sv
hdl/rub_ram.sv
hdl/radial_undistort_bilinear.sv
test/radial_undistort_bilinear_tb.sv
